@@ design/hscr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hscr_pkg
// shared types and constants of the hall sample capture ring
// ----------------------------------------------------------------------------
package hscr_pkg;

    // input operation codes
    typedef enum logic [1:0] {
        OP_SAMPLE  = 2'd0,
        OP_QUERY   = 2'd1,
        OP_RESTART = 2'd2,
        OP_UNUSED  = 2'd3
    } op_t;

    // result status codes
    typedef enum logic [2:0] {
        STAT_STORED      = 3'd0,
        STAT_READ_FAILED = 3'd1,
        STAT_LIMIT_HIT   = 3'd2,
        STAT_DROPPED     = 3'd3,
        STAT_QUERY_ENTRY = 3'd4,
        STAT_RESTARTED   = 3'd5
    } status_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_SCALE_ENABLE = 2'd0,
        CFG_GAIN_X       = 2'd1,
        CFG_GAIN_Y       = 2'd2,
        CFG_FAIL_LIMIT   = 2'd3
    } cfg_idx_t;

    localparam logic [15:0] GAIN_DEFAULT     = 16'd15284;
    localparam logic [7:0]  FAIL_LIMIT_RESET = 8'd10;
    localparam logic [7:0]  FAIL_COUNT_MAX   = 8'd255;

    // |raw| * 32767 stays below 2^30
    localparam int DVD_W     = 30;
    localparam int DIV_STEPS = DVD_W;
    localparam int DIV_CNT_W = 5;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [63:0]        stamp;
    } ring_entry_t;

    // request into one divider lane
    typedef struct packed {
        logic               start;
        logic signed [15:0] raw;
        logic [15:0]        gain;
    } div_req_t;

    // answer from one divider lane
    typedef struct packed {
        logic               done;
        logic signed [31:0] quot;
    } div_rsp_t;

endpackage : hscr_pkg
`default_nettype wire

@@ design/hscr_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hscr_div
// bit-serial signed scaling lane: raw * 32767 / gain, truncating toward zero
// ----------------------------------------------------------------------------
module hscr_div
    import hscr_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic                 active_reg, active_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [16:0]          rem_reg, rem_next;
    logic [DVD_W-1:0]     dvd_reg, dvd_next;
    logic [15:0]          gain_reg, gain_next;
    logic                 neg_reg, neg_next;

    logic [16:0] raw_ext;
    logic [16:0] mag;
    logic [31:0] prod;
    logic [16:0] rem_sh;
    logic [17:0] diff;
    logic [31:0] q_ext;

    // magnitude times 32767 as a shift and subtract
    assign raw_ext = {req.raw[15], req.raw};
    assign mag     = req.raw[15] ? (17'd0 - raw_ext) : raw_ext;
    assign prod    = {mag, 15'd0} - {15'd0, mag};

    // one restoring step per cycle
    assign rem_sh = {rem_reg[15:0], dvd_reg[DVD_W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, gain_reg};

    always_comb
    begin
        active_next = active_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        dvd_next    = dvd_reg;
        gain_next   = gain_reg;
        neg_next    = neg_reg;
        if (req.start)
        begin
            active_next = 1'b1;
            cnt_next    = '0;
            rem_next    = '0;
            dvd_next    = prod[DVD_W-1:0];
            gain_next   = (req.gain == 16'd0) ? GAIN_DEFAULT : req.gain;
            neg_next    = req.raw[15];
        end
        else if (active_reg)
        begin
            if (!diff[17])
            begin
                rem_next = diff[16:0];
                dvd_next = {dvd_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dvd_reg  <= dvd_next;
        gain_reg <= gain_next;
        neg_reg  <= neg_next;
    end

    assign q_ext    = {{(32 - DVD_W){1'b0}}, dvd_reg};
    assign rsp.done = done_reg;
    assign rsp.quot = neg_reg ? (32'd0 - q_ext) : q_ext;

endmodule : hscr_div
`default_nettype wire

@@ design/hscr_ring.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hscr_ring
// sample store: one write port, one registered read port
// ----------------------------------------------------------------------------
module hscr_ring
    import hscr_pkg::*;
#(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5
)
(
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire ring_entry_t       wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output ring_entry_t            rd_data
);

    ring_entry_t mem [DEPTH];
    ring_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule : hscr_ring
`default_nettype wire

@@ design/hall_sample_capture_ring.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hall_sample_capture_ring
// capture ring for optical stabilizer hall samples
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. After reset the block
// zeroes its sample store, one entry per cycle, so busy stays high until every
// entry is cleared (config writes are taken meanwhile). Each result shows on
// the result ports for exactly one cycle with result_valid high; the receiver
// cannot stall it. Timing per item: restart, failed reads, dropped samples
// and unscaled good samples give their result the cycle after acceptance and
// leave busy low. A scaled good sample runs the x and y lanes of the
// bit-serial divider side by side, one quotient bit a cycle, busy high until
// the lanes are done. A query streams QUERY_COUNT entries, one per cycle off
// the store's read port, oldest first, last set on the final one, busy high
// while they are read. Operation code 3 is taken and ignored.
// ----------------------------------------------------------------------------
module hall_sample_capture_ring
    import hscr_pkg::*;
#(
    parameter int RING_DEPTH  = 32,
    parameter int QUERY_COUNT = 8
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // command channel
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         operation,
    input  wire logic               read_ok,
    input  wire logic signed [15:0] x_raw,
    input  wire logic signed [15:0] y_raw,
    input  wire logic [63:0]        stamp,
    // config write channel
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    // results
    output logic                    result_valid,
    output logic [2:0]              status,
    output logic signed [31:0]      x_shift,
    output logic signed [31:0]      y_shift,
    output logic [63:0]             entry_stamp,
    output logic [7:0]              fail_count,
    output logic                    last
);

    localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int QCNT_W = (QUERY_COUNT > 1) ? $clog2(QUERY_COUNT) : 1;
    // a query starting point lies this far behind the write pointer
    localparam int Q_BACK = QUERY_COUNT % RING_DEPTH;

    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_DIVIDE = 4'b0100,
        ST_QUERY  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // config registers
    logic        scale_en_reg;
    logic [15:0] gain_x_reg;
    logic [15:0] gain_y_reg;
    logic [7:0]  fail_limit_reg;

    // block state
    logic [PTR_W-1:0]  wp_reg, wp_next;
    logic [7:0]        fcnt_reg, fcnt_next;
    logic              err_reg, err_next;
    logic [PTR_W-1:0]  clr_ptr_reg, clr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] qcnt_reg, qcnt_next;
    logic [63:0]       stamp_hold_reg, stamp_hold_next;

    // result registers
    logic        res_valid_reg, res_valid_next;
    logic        res_ring_reg, res_ring_next;
    status_t     res_status_reg, res_status_next;
    logic [31:0] res_x_reg, res_x_next;
    logic [31:0] res_y_reg, res_y_next;
    logic [63:0] res_stamp_reg, res_stamp_next;
    logic [7:0]  res_fcnt_reg, res_fcnt_next;
    logic        res_last_reg, res_last_next;

    // datapath links
    logic             accept;
    op_t              op;
    logic [7:0]       fcnt_inc;
    logic [PTR_W-1:0] wp_wrap;
    logic [PTR_W-1:0] q_start;
    logic             ring_wr_en;
    logic [PTR_W-1:0] ring_wr_addr;
    ring_entry_t      ring_wr_data;
    logic             ring_rd_en;
    ring_entry_t      ring_rd_data;
    div_req_t         div_x_req, div_y_req;
    div_rsp_t         div_x_rsp, div_y_rsp;
    logic [31:0]      x_ext, y_ext;

    assign accept = start && (state_reg != ST_CLEAR) && (state_reg != ST_DIVIDE)
                    && (state_reg != ST_QUERY);
    assign busy   = (state_reg != ST_IDLE);
    assign op     = op_t'(operation);

    // saturating failure count
    assign fcnt_inc = (fcnt_reg == FAIL_COUNT_MAX) ? fcnt_reg : fcnt_reg + 8'd1;

    // write pointer after this write, wrapping at the ring depth
    assign wp_wrap = (wp_reg == PTR_W'(RING_DEPTH - 1)) ? '0 : wp_reg + 1'b1;

    // oldest entry of a query, modulo the ring depth
    assign q_start = (wp_reg >= PTR_W'(Q_BACK)) ? wp_reg - PTR_W'(Q_BACK)
                                                : wp_reg + PTR_W'(RING_DEPTH - Q_BACK);

    assign x_ext = {{16{x_raw[15]}}, x_raw};
    assign y_ext = {{16{y_raw[15]}}, y_raw};

    // config write channel, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_en_reg   <= 1'b0;
            gain_x_reg     <= '0;
            gain_y_reg     <= '0;
            fail_limit_reg <= FAIL_LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_SCALE_ENABLE: scale_en_reg   <= cfg_data[0];
                CFG_GAIN_X:       gain_x_reg     <= cfg_data;
                CFG_GAIN_Y:       gain_y_reg     <= cfg_data;
                CFG_FAIL_LIMIT:   fail_limit_reg <= cfg_data[7:0];
                default:          ;
            endcase
        end
    end

    // divider lanes
    assign div_x_req.start = 1'b0 | (accept && op == OP_SAMPLE && !err_reg && read_ok
                                     && scale_en_reg);
    assign div_x_req.raw   = x_raw;
    assign div_x_req.gain  = gain_x_reg;
    assign div_y_req.start = div_x_req.start;
    assign div_y_req.raw   = y_raw;
    assign div_y_req.gain  = gain_y_reg;

    hscr_div u_div_x
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_x_req),
        .rsp   (div_x_rsp)
    );

    hscr_div u_div_y
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_y_req),
        .rsp   (div_y_rsp)
    );

    // main sequencer
    always_comb
    begin
        state_next      = state_reg;
        wp_next         = wp_reg;
        fcnt_next       = fcnt_reg;
        err_next        = err_reg;
        clr_ptr_next    = clr_ptr_reg;
        rd_ptr_next     = rd_ptr_reg;
        qcnt_next       = qcnt_reg;
        stamp_hold_next = stamp_hold_reg;

        res_valid_next  = 1'b0;
        res_ring_next   = 1'b0;
        res_status_next = res_status_reg;
        res_x_next      = res_x_reg;
        res_y_next      = res_y_reg;
        res_stamp_next  = res_stamp_reg;
        res_fcnt_next   = res_fcnt_reg;
        res_last_next   = res_last_reg;

        ring_wr_en   = 1'b0;
        ring_wr_addr = wp_reg;
        ring_wr_data = '0;
        ring_rd_en   = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                // zero one store entry per cycle
                ring_wr_en   = 1'b1;
                ring_wr_addr = clr_ptr_reg;
                clr_ptr_next = clr_ptr_reg + 1'b1;
                if (clr_ptr_reg == PTR_W'(RING_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    case (op)
                        OP_SAMPLE:
                        begin
                            res_x_next     = '0;
                            res_y_next     = '0;
                            res_stamp_next = '0;
                            res_last_next  = 1'b1;
                            if (err_reg)
                            begin
                                res_valid_next  = 1'b1;
                                res_status_next = STAT_DROPPED;
                                res_fcnt_next   = fcnt_reg;
                            end
                            else if (read_ok)
                            begin
                                fcnt_next = '0;
                                if (scale_en_reg)
                                begin
                                    stamp_hold_next = stamp;
                                    state_next      = ST_DIVIDE;
                                end
                                else
                                begin
                                    ring_wr_en         = 1'b1;
                                    ring_wr_data.x     = x_ext;
                                    ring_wr_data.y     = y_ext;
                                    ring_wr_data.stamp = stamp;
                                    wp_next            = wp_wrap;
                                    res_valid_next     = 1'b1;
                                    res_status_next    = STAT_STORED;
                                    res_x_next         = x_ext;
                                    res_y_next         = y_ext;
                                    res_stamp_next     = stamp;
                                    res_fcnt_next      = '0;
                                end
                            end
                            else
                            begin
                                fcnt_next      = fcnt_inc;
                                res_valid_next = 1'b1;
                                res_fcnt_next  = fcnt_inc;
                                if (fcnt_inc == fail_limit_reg)
                                begin
                                    err_next        = 1'b1;
                                    res_status_next = STAT_LIMIT_HIT;
                                end
                                else
                                begin
                                    res_status_next = STAT_READ_FAILED;
                                end
                            end
                        end

                        OP_QUERY:
                        begin
                            rd_ptr_next = q_start;
                            qcnt_next   = '0;
                            state_next  = ST_QUERY;
                        end

                        OP_RESTART:
                        begin
                            fcnt_next       = '0;
                            err_next        = 1'b0;
                            res_valid_next  = 1'b1;
                            res_status_next = STAT_RESTARTED;
                            res_x_next      = '0;
                            res_y_next      = '0;
                            res_stamp_next  = '0;
                            res_fcnt_next   = '0;
                            res_last_next   = 1'b1;
                        end

                        default:
                        begin
                            // unused code: taken, no result
                        end
                    endcase
                end
            end

            ST_DIVIDE:
            begin
                if (div_x_rsp.done)
                begin
                    ring_wr_en         = 1'b1;
                    ring_wr_data.x     = div_x_rsp.quot;
                    ring_wr_data.y     = div_y_rsp.quot;
                    ring_wr_data.stamp = stamp_hold_reg;
                    wp_next            = wp_wrap;
                    res_valid_next     = 1'b1;
                    res_status_next    = STAT_STORED;
                    res_x_next         = div_x_rsp.quot;
                    res_y_next         = div_y_rsp.quot;
                    res_stamp_next     = stamp_hold_reg;
                    res_fcnt_next      = fcnt_reg;
                    res_last_next      = 1'b1;
                    state_next         = ST_IDLE;
                end
            end

            ST_QUERY:
            begin
                // one read per cycle, the registered read data is the result
                ring_rd_en      = 1'b1;
                res_valid_next  = 1'b1;
                res_ring_next   = 1'b1;
                res_status_next = STAT_QUERY_ENTRY;
                res_fcnt_next   = fcnt_reg;
                res_last_next   = (qcnt_reg == QCNT_W'(QUERY_COUNT - 1));
                rd_ptr_next     = (rd_ptr_reg == PTR_W'(RING_DEPTH - 1)) ? '0
                                                                         : rd_ptr_reg + 1'b1;
                qcnt_next       = qcnt_reg + 1'b1;
                if (qcnt_reg == QCNT_W'(QUERY_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    hscr_ring #(
        .DEPTH  (RING_DEPTH),
        .ADDR_W (PTR_W)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ring_wr_en),
        .wr_addr (ring_wr_addr),
        .wr_data (ring_wr_data),
        .rd_en   (ring_rd_en),
        .rd_addr (rd_ptr_reg),
        .rd_data (ring_rd_data)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            wp_reg        <= '0;
            fcnt_reg      <= '0;
            err_reg       <= 1'b0;
            clr_ptr_reg   <= '0;
            rd_ptr_reg    <= '0;
            qcnt_reg      <= '0;
            res_valid_reg <= 1'b0;
            res_ring_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            fcnt_reg      <= fcnt_next;
            err_reg       <= err_next;
            clr_ptr_reg   <= clr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            qcnt_reg      <= qcnt_next;
            res_valid_reg <= res_valid_next;
            res_ring_reg  <= res_ring_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        stamp_hold_reg <= stamp_hold_next;
        res_status_reg <= res_status_next;
        res_x_reg      <= res_x_next;
        res_y_reg      <= res_y_next;
        res_stamp_reg  <= res_stamp_next;
        res_fcnt_reg   <= res_fcnt_next;
        res_last_reg   <= res_last_next;
    end

    // query entries come straight off the store's read register
    assign result_valid = res_valid_reg;
    assign status       = res_status_reg;
    assign x_shift      = res_ring_reg ? ring_rd_data.x : res_x_reg;
    assign y_shift      = res_ring_reg ? ring_rd_data.y : res_y_reg;
    assign entry_stamp  = res_ring_reg ? ring_rd_data.stamp : res_stamp_reg;
    assign fail_count   = res_fcnt_reg;
    assign last         = res_last_reg;

`ifndef SYNTHESIS
    // both divider lanes start together and must finish together
    a_lanes_lockstep : assert property (@(posedge clk) disable iff (!rst_n)
        div_x_rsp.done == div_y_rsp.done)
        else $error("divider lanes out of step");

    // query entries stream without gaps up to the one marked last
    a_query_stream : assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last) |=> result_valid)
        else $error("gap inside query transaction");

    // a latched error implies a nonzero failure count
    a_err_count : assert property (@(posedge clk) disable iff (!rst_n)
        err_reg |-> (fcnt_reg != 8'd0))
        else $error("error latched with zero failure count");

    // a stored sample always reports a cleared failure count
    a_stored_count : assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status == STAT_STORED) |-> (fail_count == 8'd0))
        else $error("stored sample with nonzero failure count");
`endif

endmodule : hall_sample_capture_ring
`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the hall sample capture ring
// ----------------------------------------------------------------------------
// Sends sample, query, restart and unused commands through the start/busy
// channel and programs the four registers while the block is idle between
// phases. A model of the ring kept in the bench predicts every result
// transaction. A monitor checks each strobed result against the oldest
// prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import hscr_pkg::*;

    localparam int RING_DEPTH    = 32;
    localparam int QUERY_COUNT   = 8;
    localparam int SCALE_NUM     = 32767;
    // longest quiet spell after the last result of a phase (unused op, divider)
    localparam int SETTLE_CYCLES = 40;
    localparam int TIMEOUT_NS    = 3_000_000;

    // one command transaction as presented on the start/busy channel
    typedef struct {
        op_t                op;
        logic               ok;
        logic signed [15:0] xr;
        logic signed [15:0] yr;
        logic [63:0]        ts;
    } hall_cmd_t;

    // one result transaction as it should appear on the result ports
    typedef struct {
        status_t            st;
        logic signed [31:0] xs;
        logic signed [31:0] ys;
        logic [63:0]        ts;
        logic [7:0]         fcnt;
        logic               lst;
    } hall_result_t;

    // clock, reset and every block input start at a known value
    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               start        = 1'b0;
    logic [1:0]         operation    = OP_SAMPLE;
    logic               read_ok      = 1'b0;
    logic signed [15:0] x_raw        = '0;
    logic signed [15:0] y_raw        = '0;
    logic [63:0]        stamp        = '0;
    logic               cfg_valid    = 1'b0;
    logic [1:0]         cfg_index    = CFG_SCALE_ENABLE;
    logic [15:0]        cfg_data     = '0;
    logic               busy;
    logic               cfg_ready;
    logic               result_valid;
    logic [2:0]         status;
    logic signed [31:0] x_shift;
    logic signed [31:0] y_shift;
    logic [63:0]        entry_stamp;
    logic [7:0]         fail_count;
    logic               last;

    // bench copy of the ring state and registers
    ring_entry_t  ring_copy [RING_DEPTH];
    int           wr_ptr      = 0;
    logic [7:0]   fail_cnt    = '0;
    logic         err_latched = 1'b0;
    logic         scale_on    = 1'b0;
    logic [15:0]  gain_x_reg  = '0;
    logic [15:0]  gain_y_reg  = '0;
    logic [7:0]   fail_lim    = FAIL_LIMIT_RESET;

    hall_cmd_t    commands_to_send [$];
    hall_result_t capture_results_due [$];
    hall_cmd_t    on_port;
    int           n_taken     = 0;
    int           n_errors    = 0;

    hall_sample_capture_ring #(
        .RING_DEPTH  (RING_DEPTH),
        .QUERY_COUNT (QUERY_COUNT)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .read_ok      (read_ok),
        .x_raw        (x_raw),
        .y_raw        (y_raw),
        .stamp        (stamp),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .status       (status),
        .x_shift      (x_shift),
        .y_shift      (y_shift),
        .entry_stamp  (entry_stamp),
        .fail_count   (fail_count),
        .last         (last)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // hard stop in case a transaction never completes
    initial
    begin
        #(TIMEOUT_NS);
        $display("FAIL");
        $finish;
    end

    task automatic flag_mismatch(string what);
        n_errors++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // shift * 32767 / gain, truncated toward zero; gain 0 means the default
    function automatic logic signed [31:0] scaled_shift(logic signed [15:0] raw,
                                                        logic [15:0] gain);
        int divisor;
        divisor = (gain == 16'd0) ? int'(GAIN_DEFAULT) : int'(gain);
        return (int'(raw) * SCALE_NUM) / divisor;
    endfunction

    // updates the bench ring for one accepted command and queues its results
    task automatic predict_capture(hall_cmd_t c);
        hall_result_t r;
        int           idx;
        r.st   = STAT_STORED;
        r.xs   = '0;
        r.ys   = '0;
        r.ts   = '0;
        r.fcnt = '0;
        r.lst  = 1'b1;
        case (c.op)
            OP_SAMPLE:
            begin
                if (err_latched)
                    r.st = STAT_DROPPED;
                else if (c.ok)
                begin
                    r.xs = scale_on ? scaled_shift(c.xr, gain_x_reg) : int'(c.xr);
                    r.ys = scale_on ? scaled_shift(c.yr, gain_y_reg) : int'(c.yr);
                    r.ts = c.ts;
                    fail_cnt = '0;
                    ring_copy[wr_ptr].x     = r.xs;
                    ring_copy[wr_ptr].y     = r.ys;
                    ring_copy[wr_ptr].stamp = c.ts;
                    wr_ptr = (wr_ptr + 1) % RING_DEPTH;
                end
                else
                begin
                    // counter saturates; error only on an exact hit of the limit
                    if (fail_cnt != FAIL_COUNT_MAX)
                        fail_cnt++;
                    if (fail_cnt == fail_lim)
                    begin
                        err_latched = 1'b1;
                        r.st = STAT_LIMIT_HIT;
                    end
                    else
                        r.st = STAT_READ_FAILED;
                end
                r.fcnt = fail_cnt;
                capture_results_due.push_back(r);
            end
            OP_QUERY:
            begin
                // oldest of the recent window first, newest carries last
                for (int k = 0; k < QUERY_COUNT; k++)
                begin
                    idx = (wr_ptr + RING_DEPTH * QUERY_COUNT - QUERY_COUNT + k) % RING_DEPTH;
                    r.st   = STAT_QUERY_ENTRY;
                    r.xs   = ring_copy[idx].x;
                    r.ys   = ring_copy[idx].y;
                    r.ts   = ring_copy[idx].stamp;
                    r.fcnt = fail_cnt;
                    r.lst  = (k == QUERY_COUNT - 1);
                    capture_results_due.push_back(r);
                end
            end
            OP_RESTART:
            begin
                // ring content survives a restart
                fail_cnt    = '0;
                err_latched = 1'b0;
                r.st        = STAT_RESTARTED;
                capture_results_due.push_back(r);
            end
            default:
            begin
                // unused code: taken and ignored
            end
        endcase
    endtask

    // driver: advances on an accepted command, inserts random gaps otherwise
    always @(posedge clk)
    begin
        logic taken;
        taken = start && !busy;
        if (rst_n)
        begin
            if (taken)
            begin
                predict_capture(on_port);
                n_taken++;
            end
            if (taken || !start)
            begin
                // a stretch of back-to-back commands in the middle of the run
                if (commands_to_send.size() != 0 &&
                    ((n_taken >= 50 && n_taken < 80) || $urandom_range(0, 99) >= 35))
                begin
                    on_port = commands_to_send.pop_front();
                    start     <= 1'b1;
                    operation <= on_port.op;
                    read_ok   <= on_port.ok;
                    x_raw     <= on_port.xr;
                    y_raw     <= on_port.yr;
                    stamp     <= on_port.ts;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor: every strobed result must match the oldest prediction
    always @(posedge clk)
    begin
        hall_result_t want;
        if (rst_n && result_valid)
        begin
            if (capture_results_due.size() == 0)
                flag_mismatch($sformatf("unexpected result, status %0d", status));
            else
            begin
                want = capture_results_due.pop_front();
                // printed as seen/wanted
                if (status !== want.st || x_shift !== want.xs || y_shift !== want.ys ||
                    entry_stamp !== want.ts || fail_count !== want.fcnt ||
                    last !== want.lst)
                    flag_mismatch($sformatf(
                        "status %0d/%0d x %0d/%0d y %0d/%0d stamp %h/%h cnt %0d/%0d last %b/%b",
                        status, want.st, x_shift, want.xs, y_shift, want.ys,
                        entry_stamp, want.ts, fail_count, want.fcnt, last, want.lst));
            end
        end
    end

    // one register write transaction; the bench copy follows at the handshake
    task automatic write_reg(cfg_idx_t idx, logic [15:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_SCALE_ENABLE: scale_on   = data[0];
            CFG_GAIN_X:       gain_x_reg = data;
            CFG_GAIN_Y:       gain_y_reg = data;
            CFG_FAIL_LIMIT:   fail_lim   = data[7:0];
            default:          ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    // unused upper data bits get random values, the block must mask them
    task automatic set_config(logic en, logic [15:0] gx, logic [15:0] gy, logic [7:0] lim);
        write_reg(CFG_SCALE_ENABLE, {15'($urandom), en});
        write_reg(CFG_GAIN_X, gx);
        write_reg(CFG_GAIN_Y, gy);
        write_reg(CFG_FAIL_LIMIT, {8'($urandom), lim});
    endtask

    // wait for every command sent and every result seen, then let it settle
    task automatic drain_phase();
        do
            @(negedge clk);
        while (commands_to_send.size() != 0 || start || capture_results_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic hall_cmd_t make_cmd(op_t op, logic ok, int xr, int yr,
                                           logic [63:0] ts);
        hall_cmd_t c;
        c.op = op;
        c.ok = ok;
        c.xr = 16'(xr);
        c.yr = 16'(yr);
        c.ts = ts;
        return c;
    endfunction

    // extremes, values near zero, and full-range noise
    function automatic logic signed [15:0] rand_raw();
        case ($urandom_range(0, 7))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return 16'(int'($urandom_range(0, 16)) - 8);
            default: return 16'($urandom);
        endcase
    endfunction

    // mostly good samples, some failed reads, queries and restarts
    function automatic hall_cmd_t rand_cmd();
        hall_cmd_t   c;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        c.op = (pick < 74) ? OP_SAMPLE : (pick < 84) ? OP_QUERY :
               (pick < 96) ? OP_RESTART : OP_UNUSED;
        c.ok = ($urandom_range(0, 99) < 80);
        c.xr = rand_raw();
        c.yr = rand_raw();
        c.ts = {$urandom, $urandom};
        return c;
    endfunction

    initial
    begin
        foreach (ring_copy[i])
            ring_copy[i] = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // raw mode, short limit: extremes, error latch, drop while latched
        set_config(1'b0, 16'd0, 16'd0, 8'd3);
        commands_to_send.push_back(make_cmd(OP_QUERY, 1'b0, 0, 0, 64'd0));
        commands_to_send.push_back(make_cmd(OP_SAMPLE, 1'b1, -32768, 32767, 64'd0));
        commands_to_send.push_back(make_cmd(OP_SAMPLE, 1'b1, 32767, -32768, '1));
        commands_to_send.push_back(make_cmd(OP_SAMPLE, 1'b1, 0, -1, 64'h8000_0000_0000_0001));
        commands_to_send.push_back(make_cmd(OP_SAMPLE, 1'b1, -1, 0, 64'h7fff_ffff_ffff_fffe));
        commands_to_send.push_back(make_cmd(OP_UNUSED, 1'b1, -1, -1, '1));
        repeat (3)
            commands_to_send.push_back(make_cmd(OP_SAMPLE, 1'b0, 100, -100, 64'd5));
        commands_to_send.push_back(make_cmd(OP_SAMPLE, 1'b1, 555, 666, 64'd77));
        commands_to_send.push_back(make_cmd(OP_SAMPLE, 1'b0, 1, 2, 64'd3));
        commands_to_send.push_back(make_cmd(OP_QUERY, 1'b1, 0, 0, 64'd0));
        commands_to_send.push_back(make_cmd(OP_RESTART, 1'b0, 0, 0, 64'd0));
        commands_to_send.push_back(rand_cmd());
        commands_to_send.push_back(make_cmd(OP_SAMPLE, 1'b1, 4321, -1234, 64'hdead_beef));
        commands_to_send.push_back(make_cmd(OP_QUERY, 1'b0, 0, 0, 64'd0));
        drain_phase();

        // scaled mode: default gain on x, unit gain on y, limit of one
        set_config(1'b1, 16'd0, 16'd1, 8'd1);
        commands_to_send.push_back(make_cmd(OP_SAMPLE, 1'b1, -32768, -32768, 64'd1));
        commands_to_send.push_back(make_cmd(OP_SAMPLE, 1'b1, 32767, 32767, 64'd2));
        // truncation toward zero on a negative quotient
        commands_to_send.push_back(make_cmd(OP_SAMPLE, 1'b1, -1, 1, 64'd3));
        commands_to_send.push_back(make_cmd(OP_SAMPLE, 1'b0, 0, 0, 64'd4));
        commands_to_send.push_back(make_cmd(OP_RESTART, 1'b1, 0, 0, 64'd0));
        commands_to_send.push_back(make_cmd(OP_RESTART, 1'b1, 0, 0, 64'd0));
        commands_to_send.push_back(make_cmd(OP_SAMPLE, 1'b1, 12345, -23456, 64'd5));
        commands_to_send.push_back(make_cmd(OP_QUERY, 1'b0, 0, 0, 64'd0));
        drain_phase();

        // climb under a high limit, then keep counting past a lower one
        set_config(1'b0, 16'd1000, 16'd65535, 8'd255);
        commands_to_send.push_back(make_cmd(OP_RESTART, 1'b0, 0, 0, 64'd0));
        repeat (6)
            commands_to_send.push_back(make_cmd(OP_SAMPLE, 1'b0, rand_raw(), rand_raw(),
                                                {$urandom, $urandom}));
        drain_phase();
        set_config(1'b1, 16'd65535, 16'd0, 8'd3);
        repeat (10)
            commands_to_send.push_back(make_cmd(OP_SAMPLE, 1'b0, rand_raw(), rand_raw(),
                                                {$urandom, $urandom}));
        commands_to_send.push_back(make_cmd(OP_SAMPLE, 1'b1, -32768, 32767, 64'd9));
        commands_to_send.push_back(make_cmd(OP_SAMPLE, 1'b0, 0, 0, 64'd0));
        commands_to_send.push_back(make_cmd(OP_RESTART, 1'b0, 0, 0, 64'd0));
        drain_phase();

        // random traffic under a spread of register settings
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: set_config(1'b1, 16'd1, 16'd65535, 8'd1);
                1: set_config(1'b1, 16'($urandom_range(1, 65535)),
                              16'($urandom_range(0, 65535)), 8'($urandom_range(2, 12)));
                2: set_config(1'b0, 16'($urandom), 16'($urandom), 8'($urandom_range(1, 6)));
                default: set_config(1'b1, 16'($urandom_range(2, 40)),
                                    16'($urandom_range(30000, 65535)), 8'd255);
            endcase
            repeat (22)
                commands_to_send.push_back(rand_cmd());
            drain_phase();
        end

        if (n_errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
